// ----- sv/mset_pkg.sv -----
// shared types and constants for the multi-slot event timer
package mset_pkg;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_KILL    = 2'd1,
        OP_SERVICE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARM,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [1:0]  K_ARM  = 2'd0;
    localparam logic [1:0]  K_KILL = 2'd1;
    localparam logic [1:0]  K_FIRE = 2'd2;

    localparam logic        ST_OK  = 1'b0;
    localparam logic        ST_REJ = 1'b1;

    localparam logic [19:0] DELAY_MIN = 20'd1;
    localparam logic [19:0] DELAY_MAX = 20'd1000000;
    localparam logic [31:0] ID_FIRST  = 32'd1;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] handler;
        logic [31:0] user;
        logic [19:0] period;
        logic [31:0] deadline;
        logic        repeats;
    } t_slot;

    typedef struct packed {
        logic cap;
        logic arm;
        logic rd_en;
        logic take;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hit;
        logic pend;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/mset_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module mset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mset_ctrl.sv -----
// controller: item sequencing and slot scan counters
module mset_ctrl #(
    parameter int SLOTS = 8,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mset_pkg::t_op        i_op,
    output logic                 o_in_ready,
    input  mset_pkg::t_stat      i_stat,
    output mset_pkg::t_cmd       o_cmd,
    output logic [IDX_W-1:0]     o_rd_idx,
    output logic [IDX_W-1:0]     o_chk_idx
);

    mset_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_rd_cnt, n_rd_cnt;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_chk_vld, n_chk_vld;
    logic             rd_more;
    logic             emit_need;

    assign rd_more   = r_rd_cnt < CNT_W'(SLOTS);
    assign o_rd_idx  = r_rd_cnt[IDX_W-1:0];
    assign o_chk_idx = r_chk_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mset_pkg::S_IDLE;
            r_rd_cnt  <= '0;
            r_chk_idx <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_chk_idx <= n_chk_idx;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_chk_idx  = r_chk_idx;
        n_chk_vld  = r_chk_vld;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        emit_need  = 1'b0;
        case (r_state)
            mset_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
                if (i_in_valid) begin
                    case (i_op)
                        mset_pkg::OP_ARM: begin
                            n_state = mset_pkg::S_ARM;
                        end
                        mset_pkg::OP_KILL, mset_pkg::OP_SERVICE: begin
                            n_state   = mset_pkg::S_SCAN;
                            n_rd_cnt  = '0;
                            n_chk_vld = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            mset_pkg::S_ARM: begin
                if (i_stat.out_free) begin
                    o_cmd.arm = 1'b1;
                    n_state   = mset_pkg::S_IDLE;
                end
            end
            mset_pkg::S_SCAN: begin
                emit_need = r_chk_vld && i_stat.hit &&
                            (i_stat.pend || i_stat.op == mset_pkg::OP_KILL);
                if (!emit_need || i_stat.out_free) begin
                    o_cmd.rd_en = rd_more;
                    o_cmd.take  = r_chk_vld;
                    n_rd_cnt    = r_rd_cnt + CNT_W'(rd_more);
                    n_chk_vld   = rd_more;
                    n_chk_idx   = r_rd_cnt[IDX_W-1:0];
                    if (r_chk_vld && i_stat.hit && i_stat.op == mset_pkg::OP_KILL) begin
                        n_state = mset_pkg::S_IDLE;
                    end else if (r_chk_vld && r_chk_idx == IDX_W'(SLOTS - 1)) begin
                        n_state = mset_pkg::S_DONE;
                    end
                end
            end
            mset_pkg::S_DONE: begin
                emit_need = i_stat.pend || i_stat.op == mset_pkg::OP_KILL;
                if (!emit_need || i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = mset_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mset_pkg::S_IDLE;
            end
        endcase
    end

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mset_pkg::S_SCAN && r_chk_vld |->
            r_rd_cnt == CNT_W'(r_chk_idx) + CNT_W'(1))
        else $error("scan read counter out of step with check stage");

    a_kill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mset_pkg::S_SCAN && r_chk_vld && i_stat.hit &&
        i_stat.op == mset_pkg::OP_KILL && i_stat.out_free |=>
            r_state == mset_pkg::S_IDLE)
        else $error("kill match did not end the scan");

endmodule

// ----- sv/mset_dp.sv -----
// datapath: item capture, slot table, pending fire beat and output register
module mset_dp #(
    parameter int SLOTS = 8,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mset_pkg::t_cmd       i_cmd,
    input  logic [IDX_W-1:0]     i_rd_idx,
    input  logic [IDX_W-1:0]     i_chk_idx,
    output mset_pkg::t_stat      o_stat,
    input  logic [1:0]           i_operation,
    input  logic [31:0]          i_now_ms,
    input  logic [19:0]          i_delay_ms,
    input  logic                 i_periodic,
    input  logic [31:0]          i_handler_tag,
    input  logic [31:0]          i_user_value,
    input  logic [31:0]          i_kill_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_kind,
    output logic                 o_status,
    output logic [31:0]          o_timer_id,
    output logic [31:0]          o_fired_handler,
    output logic [31:0]          o_fired_user,
    output logic                 o_last
);

    localparam int SLOT_W = $bits(mset_pkg::t_slot);

    mset_pkg::t_op    r_op;
    logic [31:0]      r_now, r_tag, r_user, r_kid;
    logic [19:0]      r_delay;
    logic             r_per;
    logic [SLOTS-1:0] r_slot_vld;
    logic [31:0]      r_next_id;
    logic             r_pend;
    logic [31:0]      r_pend_id, r_pend_tag, r_pend_user;
    logic             r_out_vld;
    logic [1:0]       r_kind;
    logic             r_status, r_last;
    logic [31:0]      r_out_id, r_out_tag, r_out_user;

    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             delay_ok, arm_ok, out_free, hit, take_hit;
    logic [31:0]      id_use, diff;
    mset_pkg::t_slot  rd_slot, wr_slot;
    logic [SLOT_W-1:0] rd_word;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             out_load;
    logic [1:0]       n_kind;
    logic             n_status, n_last;
    logic [31:0]      n_out_id, n_out_tag, n_out_user;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_vld[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign delay_ok = r_delay >= mset_pkg::DELAY_MIN && r_delay <= mset_pkg::DELAY_MAX;
    assign arm_ok   = delay_ok && free_any;
    assign out_free = !r_out_vld || i_out_ready;
    assign id_use   = (r_next_id == '0) ? mset_pkg::ID_FIRST : r_next_id;
    assign rd_slot  = mset_pkg::t_slot'(rd_word);
    assign diff     = r_now - rd_slot.deadline;

    always_comb begin
        if (r_op == mset_pkg::OP_KILL) begin
            hit = r_slot_vld[i_chk_idx] && r_kid != '0 && rd_slot.ident == r_kid;
        end else begin
            hit = r_slot_vld[i_chk_idx] && !diff[31];
        end
    end

    assign take_hit = i_cmd.take && hit;

    assign o_stat.op       = r_op;
    assign o_stat.hit      = hit;
    assign o_stat.pend     = r_pend;
    assign o_stat.out_free = out_free;

    // table write: new arm or periodic re-arm
    always_comb begin
        we      = 1'b0;
        waddr   = i_chk_idx;
        wr_slot = rd_slot;
        wr_slot.deadline = r_now + {12'd0, rd_slot.period};
        if (i_cmd.arm) begin
            we               = arm_ok;
            waddr            = free_idx;
            wr_slot.ident    = id_use;
            wr_slot.handler  = r_tag;
            wr_slot.user     = r_user;
            wr_slot.period   = r_delay;
            wr_slot.deadline = r_now + {12'd0, r_delay};
            wr_slot.repeats  = r_per;
        end else if (take_hit && r_op == mset_pkg::OP_SERVICE && rd_slot.repeats) begin
            we = 1'b1;
        end
    end

    mset_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_slot),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op    <= mset_pkg::t_op'(i_operation);
            r_now   <= i_now_ms;
            r_delay <= i_delay_ms;
            r_per   <= i_periodic;
            r_tag   <= i_handler_tag;
            r_user  <= i_user_value;
            r_kid   <= i_kill_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_next_id  <= mset_pkg::ID_FIRST;
            r_pend     <= 1'b0;
        end else begin
            if (i_cmd.arm && arm_ok) begin
                r_slot_vld[free_idx] <= 1'b1;
                r_next_id            <= id_use + 32'd1;
            end
            if (take_hit && (r_op == mset_pkg::OP_KILL || !rd_slot.repeats)) begin
                r_slot_vld[i_chk_idx] <= 1'b0;
            end
            if (take_hit && r_op == mset_pkg::OP_SERVICE) begin
                r_pend <= 1'b1;
            end else if (i_cmd.fin || i_cmd.cap) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit && r_op == mset_pkg::OP_SERVICE) begin
            r_pend_id   <= rd_slot.ident;
            r_pend_tag  <= rd_slot.handler;
            r_pend_user <= rd_slot.user;
        end
    end

    // next output beat
    always_comb begin
        out_load   = 1'b0;
        n_kind     = mset_pkg::K_FIRE;
        n_status   = mset_pkg::ST_OK;
        n_out_id   = r_pend_id;
        n_out_tag  = r_pend_tag;
        n_out_user = r_pend_user;
        n_last     = 1'b1;
        if (i_cmd.arm) begin
            out_load   = 1'b1;
            n_kind     = mset_pkg::K_ARM;
            n_status   = arm_ok ? mset_pkg::ST_OK : mset_pkg::ST_REJ;
            n_out_id   = arm_ok ? id_use : 32'd0;
            n_out_tag  = '0;
            n_out_user = '0;
        end else if (take_hit && r_op == mset_pkg::OP_KILL) begin
            out_load   = 1'b1;
            n_kind     = mset_pkg::K_KILL;
            n_out_id   = '0;
            n_out_tag  = '0;
            n_out_user = '0;
        end else if (take_hit && r_pend) begin
            out_load = 1'b1;
            n_last   = 1'b0;
        end else if (i_cmd.fin && r_op == mset_pkg::OP_KILL) begin
            out_load   = 1'b1;
            n_kind     = mset_pkg::K_KILL;
            n_status   = mset_pkg::ST_REJ;
            n_out_id   = '0;
            n_out_tag  = '0;
            n_out_user = '0;
        end else if (i_cmd.fin && r_pend) begin
            out_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind     <= n_kind;
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_tag  <= n_out_tag;
            r_out_user <= n_out_user;
            r_last     <= n_last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_kind          = r_kind;
    assign o_status        = r_status;
    assign o_timer_id      = r_out_id;
    assign o_fired_handler = r_out_tag;
    assign o_fired_user    = r_out_user;
    assign o_last          = r_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output beat overwritten before taken");

    a_arm_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.arm && arm_ok |=> r_slot_vld != '0 && r_next_id != $past(r_next_id))
        else $error("arm did not take a slot");

    a_pend_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_op == mset_pkg::OP_SERVICE)
        else $error("pending fire beat outside service");

endmodule

// ----- sv/multi_slot_event_timer.sv -----
// top level of the multi-slot event timer
// arm: the item is captured, then armed and its result beat loaded once the output register is free
// kill and service: one slot checked per cycle while no beat waits on a full output
//   register; a new item is accepted only in the idle state; a kill hit ends the scan early
// a beat waits while the output register is full; one ram read port
// reset clears all slot valid bits and sets the next identifier to one; no clear pass
module multi_slot_event_timer #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_now_ms,
    input  logic [19:0] i_delay_ms,
    input  logic        i_periodic,
    input  logic [31:0] i_handler_tag,
    input  logic [31:0] i_user_value,
    input  logic [31:0] i_kill_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic        o_status,
    output logic [31:0] o_timer_id,
    output logic [31:0] o_fired_handler,
    output logic [31:0] o_fired_user,
    output logic        o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mset_pkg::t_cmd   cmd;
    mset_pkg::t_stat  stat;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] chk_idx;

    mset_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (mset_pkg::t_op'(i_operation)),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx),
        .o_chk_idx  (chk_idx)
    );

    mset_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_idx        (rd_idx),
        .i_chk_idx       (chk_idx),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_now_ms        (i_now_ms),
        .i_delay_ms      (i_delay_ms),
        .i_periodic      (i_periodic),
        .i_handler_tag   (i_handler_tag),
        .i_user_value    (i_user_value),
        .i_kill_id       (i_kill_id),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_timer_id      (o_timer_id),
        .o_fired_handler (o_fired_handler),
        .o_fired_user    (o_fired_user),
        .o_last          (o_last)
    );

endmodule
